### hdl/rolc_pkg.sv
// ----------------------------------------------------------------------------
// rolc_pkg
// Shared types and constants for the rectangle overlap legality checker:
// command codes and the bit layout of the stream beats.
// ----------------------------------------------------------------------------
`default_nettype none

package rolc_pkg;

  // command carried in tuser of the input stream
  typedef enum logic [1:0] {
    CMD_LOAD_MOV = 2'd0,
    CMD_LOAD_FIX = 2'd1,
    CMD_CHECK    = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  // width of each coordinate field on the input stream
  localparam int unsigned FIELD_BITS = 24;

  // input tdata layout, lowest bit first
  localparam int unsigned X_LSB      = 0;
  localparam int unsigned Y_LSB      = X_LSB + FIELD_BITS;
  localparam int unsigned W_LSB      = Y_LSB + FIELD_BITS;
  localparam int unsigned H_LSB      = W_LSB + FIELD_BITS;
  localparam int unsigned ACTIVE_BIT = H_LSB + FIELD_BITS;
  localparam int unsigned STOP_BIT   = ACTIVE_BIT + 1;
  localparam int unsigned IN_USED    = STOP_BIT + 1;
  localparam int unsigned IN_TDATA_W = ((IN_USED + 7) / 8) * 8;
  localparam int unsigned IN_TUSER_W = 2;

  // output tdata holds the legal bit, padded to one byte
  localparam int unsigned OUT_TDATA_W = 8;

endpackage : rolc_pkg

`default_nettype wire

### hdl/rectangle_overlap_legality_check.sv
// ----------------------------------------------------------------------------
// rectangle_overlap_legality_check
// Keeps a store of movable and a store of fixed rectangles in two
// synchronous memories and, on a check command, walks all movable pairs and
// all movable/fixed pairs for strict overlap, answering with one legal bit.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (lsb first)                            | tuser
//  ---------+-----+----------------------------------------------+-----------
//  s_axis   | in  | x_pos, y_pos, rect_width, rect_height,       | cmd
//           |     | active, stop_at_first, zero pad to 104 bits  |
//  m_axis   | out | legal, zero pad to 8 bits                    | -
//
//  loads and clears are done in idle and leave the state unchanged; a check
//  beat produces one output beat once its walk is through: one movable read
//  for the pivot, then one store read per pair through the single read port
//  of each memory, then the compare pipe drains.
//  with stop_at_first the walk stops issuing once an overlap is flagged.
//  reset empties both stores through their counts; memory contents are kept.
//  input is taken only while no walk runs; a waiting output beat holds only
//  the end of the next walk, loads and clears still go in.
//
`default_nettype none

module rectangle_overlap_legality_check
  import rolc_pkg::*;
#(
  parameter int unsigned MAX_MOVABLE = 256,
  parameter int unsigned MAX_FIXED   = 256,
  parameter int unsigned COORD_BITS  = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // x_pos, y_pos, rect_width, rect_height, active, stop_at_first, pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // cmd
  input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser_i,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // legal, pad
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned MW  = 4 * CB;
  localparam int unsigned MAW = $clog2(MAX_MOVABLE);
  localparam int unsigned FAW = (MAX_FIXED > 1) ? $clog2(MAX_FIXED) : 1;
  localparam int unsigned MCW = $clog2(MAX_MOVABLE + 1);
  localparam int unsigned FCW = $clog2(MAX_FIXED + 1);
  localparam int unsigned JW  = (MCW > FCW) ? MCW : FCW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_I,
    S_HOLD_I,
    S_MOV,
    S_FIX,
    S_DRAIN,
    S_DONE
  } state_e;

  // input field decode
  logic        in_fire;
  cmd_e        cmd;
  logic [31:0] x_ext, y_ext, w_ext, h_ext;
  logic [MW-1:0] wr_word;
  logic        in_active, in_stop;

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd       = cmd_e'(s_axis_tuser_i);
  assign x_ext     = {{(32-FIELD_BITS){1'b0}}, s_axis_tdata_i[X_LSB +: FIELD_BITS]};
  assign y_ext     = {{(32-FIELD_BITS){1'b0}}, s_axis_tdata_i[Y_LSB +: FIELD_BITS]};
  assign w_ext     = {{(32-FIELD_BITS){1'b0}}, s_axis_tdata_i[W_LSB +: FIELD_BITS]};
  assign h_ext     = {{(32-FIELD_BITS){1'b0}}, s_axis_tdata_i[H_LSB +: FIELD_BITS]};
  assign in_active = s_axis_tdata_i[ACTIVE_BIT];
  assign in_stop   = s_axis_tdata_i[STOP_BIT];
  assign wr_word   = {h_ext[CB-1:0], w_ext[CB-1:0], y_ext[CB-1:0], x_ext[CB-1:0]};

  // control registers
  state_e          state_q, state_d;
  logic [MCW-1:0]  mc_q, mc_d;
  logic [FCW-1:0]  fc_q, fc_d;
  logic [MCW-1:0]  i_q, i_d;
  logic [JW-1:0]   j_q, j_d;
  logic            stop_q, stop_d;
  logic            found_q, found_d;
  logic            out_valid_q, out_valid_d;
  logic            legal_q, legal_d;
  logic            v1_q, v2_q;
  logic            issue;

  // memory ports
  logic            mov_we, fix_we;
  logic [MAW-1:0]  mov_raddr;
  logic [FAW-1:0]  fix_raddr;
  logic [MW-1:0]   mov_rd_q, fix_rd_q;
  logic [MW-1:0]   mov_mem [MAX_MOVABLE];
  logic [MW-1:0]   fix_mem [MAX_FIXED];

  // walk arithmetic on counters
  logic [MCW:0] i_inc;
  logic [JW:0]  j_inc, mc_j, fc_j;
  logic         i_more, j_mov_more, j_fix_more, fix_any;

  assign i_inc      = {1'b0, i_q} + 1'b1;
  assign j_inc      = {1'b0, j_q} + 1'b1;
  assign mc_j       = {{(JW+1-MCW){1'b0}}, mc_q};
  assign fc_j       = {{(JW+1-FCW){1'b0}}, fc_q};
  assign i_more     = i_inc < {1'b0, mc_q};
  assign j_mov_more = j_inc < mc_j;
  assign j_fix_more = j_inc < fc_j;
  assign fix_any    = fc_q != '0;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-1){1'b0}}, legal_q};

  // sequencer: loads in idle, pair walk otherwise
  always_comb begin
    state_d     = state_q;
    mc_d        = mc_q;
    fc_d        = fc_q;
    i_d         = i_q;
    j_d         = j_q;
    stop_d      = stop_q;
    out_valid_d = out_valid_q;
    legal_d     = legal_q;
    mov_we      = 1'b0;
    fix_we      = 1'b0;
    issue       = 1'b0;
    mov_raddr   = j_q[MAW-1:0];
    fix_raddr   = j_q[FAW-1:0];

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            CMD_LOAD_MOV: begin
              if (mc_q < MCW'(MAX_MOVABLE)) begin
                mov_we = 1'b1;
                mc_d   = mc_q + 1'b1;
              end
            end
            CMD_LOAD_FIX: begin
              if (in_active && (fc_q < FCW'(MAX_FIXED))) begin
                fix_we = 1'b1;
                fc_d   = fc_q + 1'b1;
              end
            end
            CMD_CHECK: begin
              stop_d  = in_stop;
              i_d     = '0;
              state_d = (mc_q == '0) ? S_DONE : S_LOAD_I;
            end
            CMD_CLEAR: begin
              mc_d = '0;
              fc_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_LOAD_I: begin
        mov_raddr = i_q[MAW-1:0];
        state_d   = S_HOLD_I;
      end
      S_HOLD_I: begin
        if (i_more) begin
          j_d     = JW'(i_inc);
          state_d = S_MOV;
        end else if (fix_any) begin
          j_d     = '0;
          state_d = S_FIX;
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_MOV: begin
        issue = 1'b1;
        if (j_mov_more) begin
          j_d = j_inc[JW-1:0];
        end else if (fix_any) begin
          j_d     = '0;
          state_d = S_FIX;
        end else if (i_more) begin
          i_d     = i_inc[MCW-1:0];
          state_d = S_LOAD_I;
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_FIX: begin
        issue = 1'b1;
        if (j_fix_more) begin
          j_d = j_inc[JW-1:0];
        end else if (i_more) begin
          i_d     = i_inc[MCW-1:0];
          state_d = S_LOAD_I;
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          legal_d     = !found_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // early end of the walk once an overlap has been seen, if stop_at_first was set
    if (stop_q && found_q &&
        (state_q == S_LOAD_I || state_q == S_HOLD_I ||
         state_q == S_MOV || state_q == S_FIX)) begin
      issue   = 1'b0;
      state_d = S_DRAIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mc_q        <= '0;
      fc_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      legal_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      mc_q        <= mc_d;
      fc_q        <= fc_d;
      i_q         <= i_d;
      j_q         <= j_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
      legal_q     <= legal_d;
    end
  end

  // rectangle stores; writes only in idle, read data used only during a walk,
  // so no write ever meets a read whose data is used
  always_ff @(posedge clk_i) begin
    if (mov_we) begin
      mov_mem[mc_q[MAW-1:0]] <= wr_word;
    end
    mov_rd_q <= mov_mem[mov_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fix_we) begin
      fix_mem[fc_q[FAW-1:0]] <= wr_word;
    end
    fix_rd_q <= fix_mem[fix_raddr];
  end

  // read stage: remember which store the beat came from
  logic src_fix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    src_fix_q <= (state_q == S_FIX);
  end

  // pivot rectangle with its far corner, latched once per outer step
  logic [CB-1:0] p_xl_q, p_yl_q;
  logic [CB:0]   p_xh_q, p_yh_q;
  logic          p_wnz_q, p_hnz_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_HOLD_I) begin
      p_xl_q  <= mov_rd_q[0 +: CB];
      p_yl_q  <= mov_rd_q[CB +: CB];
      p_xh_q  <= {1'b0, mov_rd_q[0 +: CB]} + {1'b0, mov_rd_q[2*CB +: CB]};
      p_yh_q  <= {1'b0, mov_rd_q[CB +: CB]} + {1'b0, mov_rd_q[3*CB +: CB]};
      p_wnz_q <= mov_rd_q[2*CB +: CB] != '0;
      p_hnz_q <= mov_rd_q[3*CB +: CB] != '0;
    end
  end

  // partner stage: far corner of the rectangle read this cycle
  logic [MW-1:0] o_word;
  logic [CB-1:0] o_xl_q, o_yl_q;
  logic [CB:0]   o_xh_q, o_yh_q;
  logic          o_wnz_q, o_hnz_q;

  assign o_word = src_fix_q ? fix_rd_q : mov_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    o_xl_q  <= o_word[0 +: CB];
    o_yl_q  <= o_word[CB +: CB];
    o_xh_q  <= {1'b0, o_word[0 +: CB]} + {1'b0, o_word[2*CB +: CB]};
    o_yh_q  <= {1'b0, o_word[CB +: CB]} + {1'b0, o_word[3*CB +: CB]};
    o_wnz_q <= o_word[2*CB +: CB] != '0;
    o_hnz_q <= o_word[3*CB +: CB] != '0;
  end

  // compare stage: strict overlap in both axes, folded into the sticky flag
  logic overlap;

  assign overlap = p_wnz_q && p_hnz_q && o_wnz_q && o_hnz_q &&
                   (p_xh_q > {1'b0, o_xl_q}) && (o_xh_q > {1'b0, p_xl_q}) &&
                   (p_yh_q > {1'b0, o_yl_q}) && (o_yh_q > {1'b0, p_yl_q});

  always_comb begin
    found_d = found_q;
    if (in_fire && (cmd == CMD_CHECK)) begin
      found_d = 1'b0;
    end else if (v2_q && overlap) begin
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  // checks on the walk and the compare pipe
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!v1_q && !v2_q))
    else $error("compare pipe busy while idle");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mc_q <= MCW'(MAX_MOVABLE)) && (fc_q <= FCW'(MAX_FIXED)))
    else $error("store count beyond capacity");

  a_issue_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> ($past(state_q) == S_MOV || $past(state_q) == S_FIX))
    else $error("pair read outside the walk");

  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("output beat not from a finished walk");

endmodule : rectangle_overlap_legality_check

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rectangle overlap legality checker. A table of
// directed beats covers empty stores, abutting and zero-size rectangles and
// the coordinate extremes. Random phases of loads and checks follow, with one
// pass that fills both stores. Each answer beat is compared with a model of
// both stores or a typed row, under random stalls on both streams, tail aside.
// ----------------------------------------------------------------------------

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rolc_pkg::*;

  localparam int unsigned MOV_DEPTH    = 256;
  localparam int unsigned FIX_DEPTH    = 256;
  localparam int unsigned COORD_W      = 24;
  localparam logic [23:0] CMAX         = '1;
  localparam int unsigned COL_PITCH    = 1 << 16;
  localparam int unsigned ITEM_TARGET  = 1550;
  localparam int unsigned QUIET_FROM   = 1400;
  localparam int unsigned BIG_AT       = 500;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [23:0] h;
    logic [23:0] w;
    logic [23:0] y;
    logic [23:0] x;
  } rect_t;

  typedef struct {
    cmd_e  cmd;
    rect_t r;
    logic  act;
    logic  stop;
  } beat_t;

  typedef struct {
    beat_t b;
    bit    typed;
    bit    legal;
  } row_t;

  logic                   clk_i   = 1'b0;
  logic                   rst_ni  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_data  = '0;
  logic [IN_TUSER_W-1:0]  s_user  = '0;
  logic                   s_valid = 1'b0;
  logic                   s_axis_tready_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tvalid_o;
  logic                   m_ready = 1'b0;

  // model of both stores
  rect_t       mov_store [MOV_DEPTH];
  rect_t       fix_store [FIX_DEPTH];
  int unsigned mov_cnt = 0;
  int unsigned fix_cnt = 0;

  bit          pending_legal [$];
  row_t        dir_rows [$];
  bit          quiet       = 1'b0;
  bit          exp_legal;
  int unsigned items_done  = 0;
  int unsigned beats_sent  = 0;
  int unsigned answers     = 0;
  int unsigned legal_seen  = 0;
  int unsigned peak_mov    = 0;
  int unsigned peak_fix    = 0;
  int unsigned fail_cnt    = 0;
  int unsigned cycle_cnt   = 0;

  rectangle_overlap_legality_check #(
    .MAX_MOVABLE (MOV_DEPTH),
    .MAX_FIXED   (FIX_DEPTH),
    .COORD_BITS  (COORD_W)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d answers outstanding", $time, pending_legal.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // strict overlap in both axes, top edges one bit wider so nothing wraps
  function automatic bit rects_cross(rect_t a, rect_t b);
    logic [24:0] ax_hi, bx_hi, ay_hi, by_hi;
    logic [24:0] x_top, x_bot, y_top, y_bot;
    ax_hi = {1'b0, a.x} + {1'b0, a.w};
    bx_hi = {1'b0, b.x} + {1'b0, b.w};
    ay_hi = {1'b0, a.y} + {1'b0, a.h};
    by_hi = {1'b0, b.y} + {1'b0, b.h};
    x_top = (ax_hi < bx_hi) ? ax_hi : bx_hi;
    y_top = (ay_hi < by_hi) ? ay_hi : by_hi;
    x_bot = (a.x > b.x) ? {1'b0, a.x} : {1'b0, b.x};
    y_bot = (a.y > b.y) ? {1'b0, a.y} : {1'b0, b.y};
    return (x_top > x_bot) && (y_top > y_bot);
  endfunction

  // for each movable, its later movable partners, then every fixed one
  function automatic bit placement_legal();
    for (int unsigned i = 0; i < mov_cnt; i++) begin
      for (int unsigned j = i + 1; j < mov_cnt; j++) begin
        if (rects_cross(mov_store[i], mov_store[j])) return 1'b0;
      end
      for (int unsigned j = 0; j < fix_cnt; j++) begin
        if (rects_cross(mov_store[i], fix_store[j])) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // apply one accepted beat to the model
  task automatic track_beat(input beat_t b, output bit has_answer, output bit answer);
    has_answer = 1'b0;
    answer     = 1'b1;
    case (b.cmd)
      CMD_LOAD_MOV: begin
        if (mov_cnt < MOV_DEPTH) begin
          mov_store[mov_cnt] = b.r;
          mov_cnt++;
          items_done++;
        end
      end
      CMD_LOAD_FIX: begin
        if (b.act && fix_cnt < FIX_DEPTH) begin
          fix_store[fix_cnt] = b.r;
          fix_cnt++;
          items_done++;
        end
      end
      CMD_CHECK: begin
        has_answer = 1'b1;
        answer     = placement_legal();
        if (mov_cnt > peak_mov) peak_mov = mov_cnt;
        if (fix_cnt > peak_fix) peak_fix = fix_cnt;
        items_done++;
      end
      default: begin
        mov_cnt = 0;
        fix_cnt = 0;
        items_done++;
      end
    endcase
    quiet = (items_done >= QUIET_FROM);
  endtask

  // drive one beat, with an optional gap in front, and wait for acceptance
  task automatic send_beat(input beat_t b, input bit typed, input bit typed_legal);
    int unsigned           gap;
    bit                    has_answer;
    bit                    answer;
    logic [IN_TDATA_W-1:0] word;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk_i);
      s_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    word                         = '0;
    word[X_LSB +: FIELD_BITS]    = b.r.x;
    word[Y_LSB +: FIELD_BITS]    = b.r.y;
    word[W_LSB +: FIELD_BITS]    = b.r.w;
    word[H_LSB +: FIELD_BITS]    = b.r.h;
    word[ACTIVE_BIT]             = b.act;
    word[STOP_BIT]               = b.stop;
    @(negedge clk_i);
    s_data  <= word;
    s_user  <= b.cmd;
    s_valid <= 1'b1;
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    beats_sent++;
    track_beat(b, has_answer, answer);
    if (has_answer) pending_legal = {pending_legal, (typed ? typed_legal : answer)};
  endtask

  // hold the sender until every answer has come back
  task automatic wait_for_answers();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending_legal.size() != 0) @(posedge clk_i);
  endtask

  // append one row to the directed table
  task automatic add_row(input row_t row);
    dir_rows = {dir_rows, row};
  endtask

  function automatic logic [23:0] coord(input int unsigned lo, input int unsigned hi);
    return 24'($urandom_range(hi, lo));
  endfunction

  function automatic beat_t rand_beat(input cmd_e c);
    beat_t b;
    b.cmd  = c;
    b.r.x  = 24'($urandom);
    b.r.y  = 24'($urandom);
    b.r.w  = 24'($urandom);
    b.r.h  = 24'($urandom);
    b.act  = 1'($urandom);
    b.stop = 1'($urandom);
    return b;
  endfunction

  function automatic row_t mk_row(input cmd_e c, input logic [23:0] x, input logic [23:0] y,
                                  input logic [23:0] w, input logic [23:0] h,
                                  input bit act, input bit stop,
                                  input bit typed, input bit legal);
    row_t row;
    row.b.cmd  = c;
    row.b.r.x  = x;
    row.b.r.y  = y;
    row.b.r.w  = w;
    row.b.r.h  = h;
    row.b.act  = act;
    row.b.stop = stop;
    row.typed  = typed;
    row.legal  = legal;
    return row;
  endfunction

  // rectangle shapes: scatter, disjoint columns, near the top, anything
  function automatic rect_t draw_rect(input int unsigned mode, input int unsigned col);
    rect_t r;
    case (mode)
      0: begin
        r.x = coord(0, 255);
        r.y = coord(0, 255);
        r.w = ($urandom_range(0, 7) == 0) ? 24'd0 : coord(0, 31);
        r.h = ($urandom_range(0, 7) == 0) ? 24'd0 : coord(0, 31);
      end
      1: begin
        r.x = 24'((col % 256) * COL_PITCH + $urandom_range(0, COL_PITCH / 2 - 1));
        r.w = coord(0, COL_PITCH / 2);
        r.y = 24'($urandom);
        r.h = 24'($urandom);
      end
      2: begin
        r.x = CMAX - coord(0, 63);
        r.y = CMAX - coord(0, 63);
        r.w = $urandom_range(0, 1) ? 24'($urandom) : coord(0, 63);
        r.h = $urandom_range(0, 1) ? 24'($urandom) : coord(0, 63);
      end
      default: begin
        r.x = 24'($urandom);
        r.y = 24'($urandom);
        r.w = 24'($urandom);
        r.h = 24'($urandom);
      end
    endcase
    return r;
  endfunction

  // one random phase: optional clear, a batch of loads with checks mixed in, then checks
  task automatic random_phase();
    int unsigned mode;
    int unsigned col;
    int unsigned n_mov;
    int unsigned n_fix;
    beat_t       b;
    if ($urandom_range(0, 3) != 0 || mov_cnt + fix_cnt > 24) begin
      send_beat(rand_beat(CMD_CLEAR), 1'b0, 1'b0);
    end
    mode  = $urandom_range(0, 3);
    col   = $urandom_range(0, 255);
    n_mov = $urandom_range(0, 10);
    n_fix = $urandom_range(0, 8);
    while (n_mov + n_fix > 0) begin
      if (n_mov > 0 && (n_fix == 0 || $urandom_range(0, 1) == 1)) begin
        b = rand_beat(CMD_LOAD_MOV);
        n_mov--;
      end else begin
        b     = rand_beat(CMD_LOAD_FIX);
        b.act = ($urandom_range(0, 7) != 0);
        n_fix--;
      end
      b.r = draw_rect(($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : mode, col);
      col++;
      send_beat(b, 1'b0, 1'b0);
      if ($urandom_range(0, 5) == 0) send_beat(rand_beat(CMD_CHECK), 1'b0, 1'b0);
      // stray beat of any kind
      if ($urandom_range(0, 15) == 0) begin
        send_beat(rand_beat(cmd_e'(2'($urandom_range(0, 3)))), 1'b0, 1'b0);
      end
    end
    send_beat(rand_beat(CMD_CHECK), 1'b0, 1'b0);
    if ($urandom_range(0, 2) == 0) send_beat(rand_beat(CMD_CHECK), 1'b0, 1'b0);
    if ($urandom_range(0, 5) == 0) wait_for_answers();
  endtask

  // fill both stores to the top with a legal placement, then overfill
  task automatic fill_both_stores();
    beat_t b;
    wait_for_answers();
    send_beat(rand_beat(CMD_CLEAR), 1'b0, 1'b0);
    // movables in disjoint columns, all in the lower half of y
    for (int unsigned k = 0; k < MOV_DEPTH; k++) begin
      b     = rand_beat(CMD_LOAD_MOV);
      b.r.x = 24'(k * COL_PITCH + $urandom_range(0, COL_PITCH / 2 - 1));
      b.r.w = coord(0, COL_PITCH / 2);
      b.r.y = coord(0, (1 << 22) - 1);
      b.r.h = coord(0, 1 << 22);
      send_beat(b, 1'b0, 1'b0);
    end
    // fixed ones anywhere in x, all in the upper half of y
    for (int unsigned k = 0; k < FIX_DEPTH; k++) begin
      b     = rand_beat(CMD_LOAD_FIX);
      b.act = 1'b1;
      b.r.y = 24'((1 << 23) + $urandom_range(0, (1 << 22) - 1));
      b.r.h = coord(0, 1 << 22);
      send_beat(b, 1'b0, 1'b0);
    end
    b      = rand_beat(CMD_CHECK);
    b.stop = 1'b0;
    send_beat(b, 1'b0, 1'b0);
    // both stores full: these would overlap but must be dropped
    b      = rand_beat(CMD_LOAD_MOV);
    b.r    = {CMAX, CMAX, 24'd0, 24'd0};
    b.act  = 1'b1;
    b.stop = 1'b0;
    send_beat(b, 1'b0, 1'b0);
    b.cmd  = CMD_LOAD_FIX;
    send_beat(b, 1'b0, 1'b0);
    b      = rand_beat(CMD_CHECK);
    b.stop = 1'b1;
    send_beat(b, 1'b0, 1'b0);
    wait_for_answers();
    send_beat(rand_beat(CMD_CLEAR), 1'b0, 1'b0);
  endtask

  // receiver stalls in bursts, none in the tail
  initial begin
    int unsigned hold;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        hold--;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        m_ready <= 1'b0;
        hold = $urandom_range(0, 15);
      end else begin
        m_ready <= 1'b1;
        hold = $urandom_range(0, 31);
      end
    end
  end

  // answer beat check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o === 1'b1 && m_ready) begin
      if (pending_legal.size() == 0) begin
        fail_cnt++;
        $display("%0t: answer beat with none pending, expected none, got %0b",
                 $time, m_axis_tdata_o[0]);
      end else begin
        exp_legal = pending_legal.pop_front();
        answers++;
        if (exp_legal) legal_seen++;
        if (m_axis_tdata_o[0] !== exp_legal) begin
          fail_cnt++;
          $display("%0t: legal mismatch, expected %0b, got %0b",
                   $time, exp_legal, m_axis_tdata_o[0]);
        end
      end
    end
  end

  // stimulus
  initial begin
    // directed table
    add_row(mk_row(CMD_CHECK,    24'd0,   24'd0,   24'd0,   24'd0,   0, 0, 1, 1));
    add_row(mk_row(CMD_LOAD_MOV, 24'd0,   24'd0,   CMAX,    CMAX,    1, 1, 0, 0));
    add_row(mk_row(CMD_CHECK,    24'd0,   24'd0,   24'd0,   24'd0,   0, 1, 1, 1));
    add_row(mk_row(CMD_LOAD_MOV, CMAX,    CMAX,    CMAX,    CMAX,    0, 0, 0, 0));
    add_row(mk_row(CMD_CHECK,    CMAX,    CMAX,    CMAX,    CMAX,    1, 0, 0, 0));
    add_row(mk_row(CMD_LOAD_FIX, 24'd1,   24'd1,   24'd1,   24'd1,   0, 0, 0, 0));
    add_row(mk_row(CMD_CHECK,    24'd0,   24'd0,   24'd0,   24'd0,   0, 0, 0, 0));
    add_row(mk_row(CMD_LOAD_FIX, 24'd1,   24'd1,   24'd1,   24'd1,   1, 0, 0, 0));
    add_row(mk_row(CMD_CHECK,    24'd0,   24'd0,   24'd0,   24'd0,   0, 0, 0, 0));
    add_row(mk_row(CMD_CHECK,    24'd0,   24'd0,   24'd0,   24'd0,   0, 1, 0, 0));
    add_row(mk_row(CMD_CLEAR,    CMAX,    CMAX,    CMAX,    CMAX,    1, 1, 0, 0));
    add_row(mk_row(CMD_CHECK,    CMAX,    CMAX,    CMAX,    CMAX,    1, 1, 1, 1));
    add_row(mk_row(CMD_LOAD_MOV, 24'd5,   24'd5,   24'd0,   24'd100, 0, 0, 0, 0));
    add_row(mk_row(CMD_LOAD_MOV, 24'd0,   24'd0,   24'd100, 24'd100, 0, 0, 0, 0));
    add_row(mk_row(CMD_CHECK,    24'd0,   24'd0,   24'd0,   24'd0,   0, 0, 0, 0));
    add_row(mk_row(CMD_LOAD_MOV, 24'd50,  24'd50,  24'd10,  24'd0,   1, 0, 0, 0));
    add_row(mk_row(CMD_CHECK,    24'd0,   24'd0,   24'd0,   24'd0,   0, 0, 0, 0));
    add_row(mk_row(CMD_LOAD_MOV, 24'd99,  24'd99,  24'd1,   24'd1,   0, 0, 0, 0));
    add_row(mk_row(CMD_CHECK,    24'd0,   24'd0,   24'd0,   24'd0,   0, 1, 0, 0));
    add_row(mk_row(CMD_LOAD_MOV, 24'd100, 24'd0,   24'd5,   24'd5,   0, 0, 0, 0));
    add_row(mk_row(CMD_CHECK,    24'd0,   24'd0,   24'd0,   24'd0,   0, 0, 0, 0));
    add_row(mk_row(CMD_CLEAR,    24'd0,   24'd0,   24'd0,   24'd0,   0, 0, 0, 0));
    add_row(mk_row(CMD_LOAD_FIX, 24'd0,   24'd0,   CMAX,    CMAX,    1, 0, 0, 0));
    add_row(mk_row(CMD_CHECK,    24'd0,   24'd0,   24'd0,   24'd0,   0, 0, 1, 1));
    add_row(mk_row(CMD_LOAD_MOV, 24'd10,  24'd10,  24'd10,  24'd10,  1, 1, 0, 0));

    // reset
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_beat(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].legal);
    wait_for_answers();

    while (items_done < BIG_AT) random_phase();
    fill_both_stores();
    while (items_done < ITEM_TARGET) random_phase();

    // drain
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending_legal.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d beats and %0d answers (%0d legal, %0d not legal)",
             beats_sent, answers, legal_seen, answers - legal_seen);
    $display("largest stores checked: %0d movable and %0d fixed, run took %0d cycles",
             peak_mov, peak_fix, cycle_cnt);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
